>>> rtl/gtp_pkg.sv
// Shared types, constants and tables for the go-to-point rotate-then-drive controller.
// Used by gtp_cordic, gtp_div and the top level; depends on nothing else.
package gtp_pkg;

    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD_BITS   = 8;

    // CORDIC datapath: wide enough for a 2^32 operand plus gain growth.
    localparam int CORD_W    = 36;
    localparam int STEP_BITS = $clog2(CORDIC_STEPS);

    // Divider: DIV_QB quotient bits, one per cycle.
    localparam int DEN_W        = 32;
    localparam int DIV_QB       = 18;
    localparam int NUM_W        = DEN_W + DIV_QB;
    localparam int DIV_CNT_BITS = $clog2(DIV_QB);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [15:0] INV_GAIN    = 16'd39797;
    localparam logic [18:0] TWO_PI_Q16  = 19'd411775;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_MAX   = 3'd0,
        CFG_ROT_MIN   = 3'd1,
        CFG_LIN_MAX   = 3'd2,
        CFG_LIN_MIN   = 3'd3,
        CFG_ALIGN_TOL = 3'd4,
        CFG_NEAR_DIST = 3'd5,
        CFG_ARRV_DIST = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_STANDBY = 2'd0,
        PH_ROTATE  = 2'd1,
        PH_DRIVE   = 2'd2
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_VEC, ST_ANG, ST_DIST, ST_RDIV, ST_PROG, ST_PQ,
        ST_CNUM, ST_CNUMW, ST_CDENW, ST_CDIV, ST_SPD1, ST_SPD2,
        ST_CORR1, ST_CORR2, ST_CORR3, ST_DONE
    } t_state;

    // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
    function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            4'd15:   v = 32'h0000517D;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/gtp_cordic.sv
// Iterative CORDIC in vectoring mode: one micro-rotation per cycle.
// Returns the angle in 2^-32 turns and the gain-scaled magnitude; uses gtp_pkg.
module gtp_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [gtp_pkg::CORD_W-1:0] i_x,
    input  logic signed [gtp_pkg::CORD_W-1:0] i_y,
    output logic                              o_done,
    output logic [31:0]                       o_z,
    output logic signed [gtp_pkg::CORD_W-1:0] o_mag
);
    import gtp_pkg::*;

    logic signed [CORD_W-1:0] r_x, r_y, n_x, n_y, sx, sy;
    logic [31:0]              r_z, n_z;
    logic [STEP_BITS-1:0]     r_cnt, n_cnt;
    logic                     r_busy, n_busy, r_done, n_done;

    always_comb begin
        sx     = r_x >>> r_cnt;
        sy     = r_y >>> r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt = '0;
            if (i_x == '0 && i_y == '0) begin
                n_x    = '0;
                n_y    = '0;
                n_z    = '0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (i_x[CORD_W-1]) begin
                // Fold the left half plane over by a half turn.
                n_x    = -i_x;
                n_y    = -i_y;
                n_z    = 32'h80000000;
                n_busy = 1'b1;
            end else begin
                n_x    = i_x;
                n_y    = i_y;
                n_z    = '0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (!r_y[CORD_W-1] && r_y != '0) begin
                n_x = r_x + sy;
                n_y = r_y - sx;
                n_z = r_z + atan_turn(r_cnt);
            end else begin
                n_x = r_x - sy;
                n_y = r_y + sx;
                n_z = r_z - atan_turn(r_cnt);
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_BITS'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_done = r_done;
    assign o_z    = r_z;
    assign o_mag  = r_x;

endmodule

>>> rtl/gtp_div.sv
// Restoring divider producing one quotient bit per cycle.
// The caller guarantees the top part of the numerator is below the denominator; uses gtp_pkg.
module gtp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [gtp_pkg::NUM_W-1:0]    i_numer,
    input  logic [gtp_pkg::DEN_W-1:0]    i_denom,
    output logic                         o_done,
    output logic [gtp_pkg::DIV_QB-1:0]   o_quot
);
    import gtp_pkg::*;

    logic [DEN_W-1:0]        r_rem, n_rem, r_den, n_den;
    logic [DIV_QB-1:0]       r_low, n_low;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic                    r_busy, n_busy, r_done, n_done;
    logic [DEN_W:0]          trial;
    logic                    ge;

    always_comb begin
        trial  = {r_rem, r_low[DIV_QB-1]};
        ge     = trial >= {1'b0, r_den};
        n_rem  = r_rem;
        n_den  = r_den;
        n_low  = r_low;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_numer[NUM_W-1:DIV_QB];
            n_low  = i_numer[DIV_QB-1:0];
            n_den  = i_denom;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Numerator bits shift out of the low word as quotient bits shift in.
            n_rem = ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            n_low = {r_low[DIV_QB-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_BITS'(DIV_QB - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_low <= n_low;
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

>>> rtl/go_to_point_rotate_then_drive.sv
// Top level of the go-to-point rotate-then-drive controller.
// Instantiates gtp_cordic and gtp_div; uses gtp_pkg.
//
// Usage:
//   Input channel (i_valid / o_ready) carries an opcode plus x, y and heading.
//   A load item stores a new target; a tick item carries the robot pose and
//   produces wheel directions and Q10.6 speed setpoints. Every item yields
//   exactly one result on the output channel (o_valid / i_ready).
//   Items are processed one at a time; a rotate or drive tick waits on the
//   shared CORDIC unit (three 16-step passes) and the bit-serial divider (up
//   to two 18-step passes). The next transfer can follow in the cycle after
//   the result loads. o_ready is high whenever the sequencer is idle, also
//   while a finished result still waits in the output register. If the
//   receiver stalls, the next item is computed and then held until the
//   output register frees up. Configuration writes (i_cfg_we) take effect
//   at once and must only be issued while the block is idle. Reset is
//   synchronous, active low: phase returns to stand by, the target and
//   move records clear, and the configuration registers take their
//   default values.
module go_to_point_rotate_then_drive (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [gtp_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_opcode,
    input  logic signed [gtp_pkg::COORD_BITS-1:0]  i_coord_x,
    input  logic signed [gtp_pkg::COORD_BITS-1:0]  i_coord_y,
    input  logic [gtp_pkg::ANGLE_BITS-1:0]         i_heading,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [1:0]                             o_mode,
    output logic                                   o_motors_off,
    output logic                                   o_left_reverse,
    output logic                                   o_right_reverse,
    output logic signed [15:0]                     o_left_setpoint,
    output logic signed [15:0]                     o_right_setpoint,
    output logic                                   o_arrived
);
    import gtp_pkg::*;

    function automatic logic [15:0] sat16(input logic signed [20:0] v);
        logic [15:0] r;
        if (v > 21'sd32767)       r = 16'h7FFF;
        else if (v < -21'sd32768) r = 16'h8000;
        else                      r = v[15:0];
        return r;
    endfunction

    // Configuration registers
    logic [7:0]  r_rot_max, r_rot_min, r_lin_max, r_lin_min;
    logic [14:0] r_align_tol;
    logic [15:0] r_near_dist, r_arrv_dist;

    // Sequencer and persistent state
    t_state r_state, n_state;
    t_phase r_phase;
    logic signed [COORD_BITS-1:0] r_goal_x, r_goal_y, r_px, r_py;
    logic [ANGLE_BITS-1:0] r_start_angle, r_head;
    logic [16:0] r_start_dist;
    logic [15:0] r_last_spin;
    logic        r_op;

    // Working registers
    logic signed [ANGLE_BITS-1:0] r_rel;
    logic [15:0] r_abs_rel, r_abs_s;
    logic [42:0] r_prod;
    logic [16:0] r_dist, r_ratio, r_p, r_curve;
    logic [30:0] r_pq;
    logic [31:0] r_num;
    logic [24:0] r_m1, r_m2;
    logic [15:0] r_speed;
    logic [17:0] r_rad;
    logic signed [36:0] r_cprod;
    logic        r_moff, r_lrev, r_rrev;
    logic [15:0] r_lsp, r_rsp;

    // Output register
    logic        r_out_valid, r_out_moff, r_out_lrev, r_out_rrev, r_out_arrived;
    logic [1:0]  r_out_mode;
    logic [15:0] r_out_lsp, r_out_rsp;

    // Shared units
    logic                     cord_start, cord_done;
    logic signed [CORD_W-1:0] cord_x, cord_y, cord_mag;
    logic [31:0]              cord_z;
    logic                     div_start, div_done;
    logic [NUM_W-1:0]         div_numer;
    logic [DEN_W-1:0]         div_denom;
    logic [DIV_QB-1:0]        div_q;

    // Combinational helpers
    logic signed [COORD_BITS:0]   dx, dy;
    logic [ANGLE_BITS-1:0]        bearing, sa_eff;
    logic signed [ANGLE_BITS-1:0] rel_w, sa_s;
    logic [15:0]                  abs_rel_w, abs_s_w;
    logic [42:0]                  dist_sum;
    logic [16:0]                  dist_w, sd_eff;
    logic [25:0]                  spd_sum;
    logic [15:0]                  spd_w;
    logic [34:0]                  rad_sum;
    logic signed [19:0]           fac;
    logic signed [36:0]           corr_sum;
    logic [15:0]                  corr_sat;
    logic                         curve_bad, out_free, goal_zero;

    gtp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (cord_x),
        .i_y     (cord_y),
        .o_done  (cord_done),
        .o_z     (cord_z),
        .o_mag   (cord_mag)
    );

    gtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        dx = $signed({r_goal_x[COORD_BITS-1], r_goal_x}) - $signed({r_px[COORD_BITS-1], r_px});
        dy = $signed({r_goal_y[COORD_BITS-1], r_goal_y}) - $signed({r_py[COORD_BITS-1], r_py});

        bearing   = cord_z[31:16] + {15'd0, cord_z[15]};
        rel_w     = $signed(bearing - r_head);
        abs_rel_w = rel_w[ANGLE_BITS-1] ? 16'(-rel_w) : 16'(rel_w);
        sa_eff    = (r_start_angle == '0) ? 16'(rel_w) : r_start_angle;
        sa_s      = $signed(sa_eff);
        abs_s_w   = sa_s[ANGLE_BITS-1] ? 16'(-sa_s) : 16'(sa_s);

        dist_sum = r_prod + 43'h800000;
        dist_w   = dist_sum[40:24];
        sd_eff   = (r_start_dist == '0) ? dist_w : r_start_dist;

        spd_sum = {1'b0, r_m1} + {1'b0, r_m2} + 26'd512;
        spd_w   = spd_sum[25:10];

        rad_sum  = 35'(r_abs_rel * TWO_PI_Q16) + 35'd32768;
        fac      = 20'sd65536 - $signed({2'b00, r_rad});
        corr_sum = r_cprod + 37'sd32768;
        corr_sat = sat16(21'(corr_sum >>> 16));

        curve_bad = (cord_z == '0) || cord_z[31];
        out_free  = !r_out_valid || i_ready;
        goal_zero = (r_goal_x == '0) && (r_goal_y == '0);
    end

    // Sequencer: next state and unit starts
    always_comb begin
        n_state    = r_state;
        o_ready    = (r_state == ST_IDLE);
        cord_start = 1'b0;
        cord_x     = {{(CORD_W-COORD_BITS-1-GUARD_BITS){dx[COORD_BITS]}}, dx, GUARD_BITS'(0)};
        cord_y     = {{(CORD_W-COORD_BITS-1-GUARD_BITS){dy[COORD_BITS]}}, dy, GUARD_BITS'(0)};
        div_start  = 1'b0;
        div_numer  = NUM_W'({r_abs_rel, 16'd0});
        div_denom  = DEN_W'(r_abs_s);
        case (r_state)
            ST_IDLE:   if (i_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                if (r_op) begin
                    n_state = ST_DONE;
                end else begin
                    cord_start = 1'b1;
                    n_state    = ST_VEC;
                end
            end
            ST_VEC:    if (cord_done) n_state = ST_ANG;
            ST_ANG:    n_state = ST_DIST;
            ST_DIST: begin
                case (r_phase)
                    PH_ROTATE: begin
                        if (r_abs_rel >= r_abs_s) begin
                            n_state = ST_PROG;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_RDIV;
                        end
                    end
                    PH_DRIVE: begin
                        div_numer = NUM_W'({dist_w, 16'd0});
                        div_denom = DEN_W'(sd_eff);
                        if (dist_w >= sd_eff) begin
                            n_state = ST_PROG;
                        end else begin
                            div_start = 1'b1;
                            n_state   = ST_RDIV;
                        end
                    end
                    default:   n_state = ST_DONE;
                endcase
            end
            ST_RDIV:   if (div_done) n_state = ST_PROG;
            ST_PROG:   n_state = ST_PQ;
            ST_PQ:     n_state = ST_CNUM;
            ST_CNUM: begin
                cord_start = 1'b1;
                cord_x     = CORD_W'(64'h1_0000_0000);
                cord_y     = CORD_W'(r_pq);
                n_state    = ST_CNUMW;
            end
            ST_CNUMW: begin
                // The normalizing angle atan(1/4) comes from a second pass.
                cord_x = CORD_W'(64'h1_0000_0000);
                cord_y = CORD_W'(64'h4000_0000);
                if (cord_done) begin
                    cord_start = 1'b1;
                    n_state    = ST_CDENW;
                end
            end
            ST_CDENW: begin
                div_numer = NUM_W'({r_num, 16'd0}) + NUM_W'(cord_z[31:1]);
                div_denom = cord_z;
                if (cord_done) begin
                    if (curve_bad) begin
                        n_state = ST_SPD1;
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_CDIV;
                    end
                end
            end
            ST_CDIV:   if (div_done) n_state = ST_SPD1;
            ST_SPD1:   n_state = ST_SPD2;
            ST_SPD2: begin
                if (r_phase == PH_DRIVE && r_dist >= 17'(r_near_dist)) n_state = ST_CORR1;
                else n_state = ST_DONE;
            end
            ST_CORR1:  n_state = ST_CORR2;
            ST_CORR2:  n_state = ST_CORR3;
            ST_CORR3:  n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_max   <= 8'd120;
            r_rot_min   <= 8'd80;
            r_lin_max   <= 8'd150;
            r_lin_min   <= 8'd50;
            r_align_tol <= 15'd1043;
            r_near_dist <= 16'd50;
            r_arrv_dist <= 16'd10;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_MAX:   r_rot_max   <= i_cfg_data[7:0];
                CFG_ROT_MIN:   r_rot_min   <= i_cfg_data[7:0];
                CFG_LIN_MAX:   r_lin_max   <= i_cfg_data[7:0];
                CFG_LIN_MIN:   r_lin_min   <= i_cfg_data[7:0];
                CFG_ALIGN_TOL: r_align_tol <= i_cfg_data[14:0];
                CFG_NEAR_DIST: r_near_dist <= i_cfg_data;
                CFG_ARRV_DIST: r_arrv_dist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath, persistent state and output register
    always_ff @(posedge i_clk) begin
        if (r_out_valid && i_ready) r_out_valid <= 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_op   <= i_opcode;
                    r_px   <= i_coord_x;
                    r_py   <= i_coord_y;
                    r_head <= i_heading;
                end
            end
            ST_DECODE: begin
                r_moff <= 1'b0;
                r_lrev <= 1'b0;
                r_rrev <= 1'b0;
                r_lsp  <= '0;
                r_rsp  <= '0;
                if (r_op) begin
                    r_goal_x <= r_px;
                    r_goal_y <= r_py;
                end
            end
            ST_ANG: begin
                r_rel         <= rel_w;
                r_abs_rel     <= abs_rel_w;
                r_start_angle <= sa_eff;
                r_abs_s       <= abs_s_w;
                r_prod        <= 43'(cord_mag[26:0] * INV_GAIN);
            end
            ST_DIST: begin
                r_dist       <= dist_w;
                r_start_dist <= sd_eff;
                r_ratio      <= ONE_Q16;
                case (r_phase)
                    PH_STANDBY: begin
                        r_moff        <= 1'b1;
                        r_start_angle <= '0;
                        r_start_dist  <= '0;
                        if (!goal_zero) r_phase <= PH_ROTATE;
                    end
                    PH_ROTATE, PH_DRIVE: ;
                    default:    r_phase <= PH_STANDBY;
                endcase
            end
            ST_RDIV:  if (div_done) r_ratio <= {1'b0, div_q[15:0]};
            ST_PROG:  r_p <= ONE_Q16 - r_ratio;
            ST_PQ:    r_pq <= 31'(r_p * (ONE_Q16 - r_p));
            ST_CNUMW: if (cord_done) r_num <= cord_z[31] ? 32'd0 : cord_z;
            ST_CDENW: if (cord_done) r_curve <= '0;
            ST_CDIV: begin
                if (div_done) r_curve <= (div_q > DIV_QB'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
            end
            ST_SPD1: begin
                if (r_phase == PH_ROTATE) begin
                    r_m1 <= 25'(r_rot_max * r_curve);
                    r_m2 <= 25'(r_rot_min * (ONE_Q16 - r_p));
                end else begin
                    r_m1 <= 25'(r_lin_max * r_curve);
                    r_m2 <= 25'(r_lin_min * (ONE_Q16 - r_p));
                end
            end
            ST_SPD2: begin
                r_speed <= spd_w;
                r_lsp   <= spd_w;
                r_rsp   <= spd_w;
                if (r_phase == PH_ROTATE) begin
                    r_lrev <= !r_rel[ANGLE_BITS-1] && (r_rel != '0);
                    r_rrev <= r_rel[ANGLE_BITS-1] || (r_rel == '0);
                    if (spd_w == r_last_spin && r_abs_rel <= 16'(r_align_tol)) begin
                        r_phase <= PH_DRIVE;
                    end
                    r_last_spin <= spd_w;
                end else if (r_abs_rel < 16'h4000 && r_dist < 17'(r_arrv_dist)) begin
                    r_phase  <= PH_STANDBY;
                    r_goal_x <= '0;
                    r_goal_y <= '0;
                end
            end
            ST_CORR1: r_rad <= rad_sum[33:16];
            ST_CORR2: r_cprod <= 37'($signed({1'b0, r_speed}) * fac);
            ST_CORR3: begin
                // The wheel on the side of the heading error slows down.
                if (r_rel[ANGLE_BITS-1]) r_rsp <= corr_sat;
                else r_lsp <= corr_sat;
            end
            ST_DONE: begin
                if (out_free) begin
                    r_out_valid   <= 1'b1;
                    r_out_mode    <= r_phase;
                    r_out_moff    <= r_moff;
                    r_out_lrev    <= r_lrev;
                    r_out_rrev    <= r_rrev;
                    r_out_lsp     <= r_lsp;
                    r_out_rsp     <= r_rsp;
                    r_out_arrived <= goal_zero;
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_phase       <= PH_STANDBY;
            r_goal_x      <= '0;
            r_goal_y      <= '0;
            r_start_angle <= '0;
            r_start_dist  <= '0;
            r_last_spin   <= '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mode           = r_out_mode;
    assign o_motors_off     = r_out_moff;
    assign o_left_reverse   = r_out_lrev;
    assign o_right_reverse  = r_out_rrev;
    assign o_left_setpoint  = r_out_lsp;
    assign o_right_setpoint = r_out_rsp;
    assign o_arrived        = r_out_arrived;

endmodule

>>> tb/sv/go_to_point_rotate_then_drive_check.sv
`timescale 1ns / 1ps
// Checker for the go-to-point controller: watches the item and result channels,
// predicts every result from its own copy of state and settings, and compares.
// Depends on gtp_pkg for the register index and phase codes.
module go_to_point_rotate_then_drive_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_coord_x,
    input  logic [15:0] i_coord_y,
    input  logic [15:0] i_heading,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [1:0]  i_mode,
    input  logic        i_motors_off,
    input  logic        i_left_reverse,
    input  logic        i_right_reverse,
    input  logic [15:0] i_left_setpoint,
    input  logic [15:0] i_right_setpoint,
    input  logic        i_arrived,
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_checked
);
    import gtp_pkg::*;

    typedef struct {
        logic [1:0]  mode;
        logic        motors_off;
        logic        left_rev;
        logic        right_rev;
        logic [15:0] left_sp;
        logic [15:0] right_sp;
        logic        arrived;
    } t_wheel_cmd;

    localparam longint unsigned FULL = 64'h1_0000;
    localparam longint unsigned M32  = 64'hFFFF_FFFF;

    longint unsigned arctan_tbl [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

    t_wheel_cmd cmd_q[$];

    longint unsigned w_rot_max, w_rot_min, w_lin_max, w_lin_min;
    longint unsigned tol_align, dist_near, dist_arrive;
    t_phase          cur_phase;
    longint          tgt_x, tgt_y;
    longint unsigned move_angle, move_dist, prev_spin;

    assign o_waiting = cmd_q.size();

    // Vectoring: returns the angle of (x,y) in 2^-32 turns, gain-scaled length in len.
    function automatic longint unsigned vec_angle(longint x, longint y, output longint len);
        longint unsigned z;
        longint nx, ny;
        z = 0;
        if (x == 0 && y == 0) begin
            len = 0;
            return 0;
        end
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = (z + arctan_tbl[i]) & M32;
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = (z - arctan_tbl[i]) & M32;
            end
            x = nx;
            y = ny;
        end
        len = x;
        return z;
    endfunction

    // Normalized arctangent bump atan(p(1-p))/atan(1/4), Q16.
    function automatic longint unsigned bump_q16(longint unsigned p);
        longint unsigned num, den, c;
        longint dummy;
        if (p > FULL) p = FULL;
        num = vec_angle(64'sd1 << 32, longint'(p * (FULL - p)), dummy);
        den = vec_angle(64'sd1 << 32, 64'sd1 << 30, dummy);
        if (num >= 64'h8000_0000) num = 0;
        if (den == 0 || den >= 64'h8000_0000) return 0;
        c = (num * FULL + den / 2) / den;
        return (c > FULL) ? FULL : c;
    endfunction

    function automatic longint wheel_speed(longint unsigned wmax, longint unsigned wmin,
                                           longint unsigned p);
        return longint'((wmax * bump_q16(p) + wmin * (FULL - p) + 512) >> 10);
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_wheel_cmd steer(logic op, logic [15:0] cx, logic [15:0] cy,
                                         logic [15:0] hd);
        t_wheel_cmd r;
        longint dx, dy, len, rel, sa, lsp, rsp, spin, speed, rad, corr;
        longint unsigned z, bearing, abs_rel, abs_s, goal_dist, rot_p, move_p;
        logic [15:0] spin16;
        logic [15:0] rel16;
        lsp = 0;
        rsp = 0;
        r.motors_off = 0;
        r.left_rev = 0;
        r.right_rev = 0;
        if (op) begin
            tgt_x = longint'(signed'(cx));
            tgt_y = longint'(signed'(cy));
        end else begin
            dx = tgt_x - longint'(signed'(cx));
            dy = tgt_y - longint'(signed'(cy));
            z = vec_angle(dx * 256, dy * 256, len);
            bearing = ((z + 64'h8000) & M32) >> 16;
            rel16 = bearing[15:0] - hd;
            rel = longint'(signed'(rel16));
            abs_rel = longint'(rel < 0 ? -rel : rel);
            if (move_angle == 0) move_angle = {48'd0, rel16};
            sa = longint'(signed'(move_angle[15:0]));
            abs_s = longint'(sa < 0 ? -sa : sa);
            goal_dist = (len <= 0) ? 0 : (longint'(len) * 39797 + (64'd1 << 23)) >> 24;
            if (move_dist == 0) move_dist = goal_dist;
            rot_p = FULL - ((abs_rel >= abs_s) ? FULL : abs_rel * FULL / abs_s);
            move_p = FULL - ((goal_dist >= move_dist) ? FULL
                                                      : goal_dist * FULL / move_dist);
            case (cur_phase)
                PH_STANDBY: begin
                    r.motors_off = 1;
                    move_angle = 0;
                    move_dist = 0;
                    if (tgt_x != 0 || tgt_y != 0) cur_phase = PH_ROTATE;
                end
                PH_ROTATE: begin
                    spin = wheel_speed(w_rot_max, w_rot_min, rot_p);
                    spin16 = clamp16(spin);
                    r.left_rev = (rel > 0);
                    r.right_rev = !r.left_rev;
                    lsp = spin;
                    rsp = spin;
                    if (spin16 == prev_spin[15:0] && abs_rel <= tol_align)
                        cur_phase = PH_DRIVE;
                    prev_spin = {48'd0, spin16};
                end
                PH_DRIVE: begin
                    speed = wheel_speed(w_lin_max, w_lin_min, move_p);
                    lsp = speed;
                    rsp = speed;
                    if (goal_dist >= dist_near) begin
                        rad = longint'((abs_rel * 411775 + 64'd32768) >> 16);
                        corr = (speed * (65536 - rad) + 32768) >>> 16;
                        if (rel < 0) rsp = corr;
                        else lsp = corr;
                    end
                    if (abs_rel < 16384 && goal_dist < dist_arrive) begin
                        cur_phase = PH_STANDBY;
                        tgt_x = 0;
                        tgt_y = 0;
                    end
                end
                default: cur_phase = PH_STANDBY;
            endcase
        end
        r.mode = cur_phase;
        r.left_sp = clamp16(lsp);
        r.right_sp = clamp16(rsp);
        r.arrived = (tgt_x == 0 && tgt_y == 0);
        return r;
    endfunction

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_wheel_cmd e;
        if (!i_rst_n) begin
            w_rot_max = 120;
            w_rot_min = 80;
            w_lin_max = 150;
            w_lin_min = 50;
            tol_align = 1043;
            dist_near = 50;
            dist_arrive = 10;
            cur_phase = PH_STANDBY;
            tgt_x = 0;
            tgt_y = 0;
            move_angle = 0;
            move_dist = 0;
            prev_spin = 0;
            cmd_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROT_MAX:   w_rot_max = i_cfg_data[7:0];
                    CFG_ROT_MIN:   w_rot_min = i_cfg_data[7:0];
                    CFG_LIN_MAX:   w_lin_max = i_cfg_data[7:0];
                    CFG_LIN_MIN:   w_lin_min = i_cfg_data[7:0];
                    CFG_ALIGN_TOL: tol_align = i_cfg_data[14:0];
                    CFG_NEAR_DIST: dist_near = i_cfg_data;
                    CFG_ARRV_DIST: dist_arrive = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready)
                cmd_q.push_back(steer(i_opcode, i_coord_x, i_coord_y, i_heading));
            if (i_out_valid && i_ready) begin
                if (cmd_q.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    o_fail_count++;
                end else begin
                    e = cmd_q.pop_front();
                    o_checked++;
                    compare_field("mode", e.mode, i_mode);
                    compare_field("motors_off", e.motors_off, i_motors_off);
                    compare_field("left_reverse", e.left_rev, i_left_reverse);
                    compare_field("right_reverse", e.right_rev, i_right_reverse);
                    compare_field("left_setpoint", e.left_sp, i_left_setpoint);
                    compare_field("right_setpoint", e.right_sp, i_right_setpoint);
                    compare_field("arrived", e.arrived, i_arrived);
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_checked = 0;
    end
endmodule

>>> tb/sv/go_to_point_rotate_then_drive_test.sv
`timescale 1ns / 1ps
// Top of the go-to-point controller testbench: clock, reset, settings, stimulus
// and verdict. Depends on gtp_pkg, the block, and go_to_point_rotate_then_drive_check.
module go_to_point_rotate_then_drive_test;
    import gtp_pkg::*;

    localparam int LIMIT = 1500000;
    localparam int N_RANDOM = 830;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic        opcode = 0;
    logic [15:0] coord_x = '0;
    logic [15:0] coord_y = '0;
    logic [15:0] heading = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [1:0]  mode;
    logic        motors_off, left_rev, right_rev, arrived;
    logic [15:0] left_sp, right_sp;
    int          fail_count, waiting, checked;
    int          cycles = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          ready_pct = 100;

    go_to_point_rotate_then_drive dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_opcode(opcode), .i_coord_x(coord_x), .i_coord_y(coord_y),
        .i_heading(heading),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_mode(mode), .o_motors_off(motors_off),
        .o_left_reverse(left_rev), .o_right_reverse(right_rev),
        .o_left_setpoint(left_sp), .o_right_setpoint(right_sp),
        .o_arrived(arrived)
    );

    go_to_point_rotate_then_drive_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_opcode(opcode), .i_coord_x(coord_x), .i_coord_y(coord_y),
        .i_heading(heading),
        .i_out_valid(out_valid), .i_ready(out_ready),
        .i_mode(mode), .i_motors_off(motors_off),
        .i_left_reverse(left_rev), .i_right_reverse(right_rev),
        .i_left_setpoint(left_sp), .i_right_setpoint(right_sp),
        .i_arrived(arrived),
        .o_fail_count(fail_count), .o_waiting(waiting), .o_checked(checked)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("go_to_point_rotate_then_drive_test: errors");
            $finish;
        end
    end

    // The receiver switches between full speed, light and heavy stalling.
    always @(posedge i_clk) begin
        if (cycles % 300 == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 100 :
                                             ($urandom_range(0, 1) ? 70 : 25);
        out_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    task automatic send_item(logic op, int x, int y, int h);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 140);
            if (gap > 0) begin
                in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1;
        opcode <= op;
        coord_x <= x[15:0];
        coord_y <= y[15:0];
        heading <= h[15:0];
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Lets every outstanding result drain, then covers the block's own latency.
    task automatic drain();
        in_valid <= 0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_settings(int rmax, int rmin, int lmax, int lmin,
                                  int tol, int near_d, int arrive_d);
        int vals [7];
        vals = '{rmax, rmin, lmax, lmin, tol, near_d, arrive_d};
        for (int i = 0; i < 7; i++) begin
            cfg_we <= 1;
            cfg_idx <= 3'(i);
            cfg_data <= vals[i][15:0];
            @(posedge i_clk);
        end
        cfg_we <= 0;
    endtask

    // A full move: load a target, then ticks whose pose turns towards it and
    // closes in, so the block walks through rotate, drive and arrival.
    task automatic run_move(ref int budget);
        int gx, gy, px, py, h, diff, n;
        real b;
        gx = $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535) - 32768
                                       : $urandom_range(0, 6000) - 3000;
        gy = $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535) - 32768
                                       : $urandom_range(0, 6000) - 3000;
        px = gx + $urandom_range(0, 4000) - 2000;
        py = gy + $urandom_range(0, 4000) - 2000;
        if (px > 32767) px = 32767;
        if (px < -32768) px = -32768;
        if (py > 32767) py = 32767;
        if (py < -32768) py = -32768;
        h = $urandom_range(0, 65535);
        send_item(1, gx, gy, $urandom_range(0, 65535));
        budget--;
        n = $urandom_range(20, 45);
        while (n > 0 && budget > 0) begin
            send_item(0, px, py, h);
            budget--;
            n--;
            b = $atan2(real'(gy - py), real'(gx - px)) * 65536.0 / 6.283185307;
            diff = (($rtoi(b) - h) % 65536 + 65536 + 32768) % 65536 - 32768;
            h = (h + diff / 2 + $urandom_range(0, 2) - 1 + 65536) % 65536;
            if (diff < 600 && diff > -600) begin
                px = px + (gx - px) * 3 / 10;
                py = py + (gy - py) * 3 / 10;
                if (px - gx < 4 && gx - px < 4) px = gx;
                if (py - gy < 4 && gy - py < 4) py = gy;
            end
        end
    endtask

    task automatic random_phase(int count);
        int budget;
        budget = count;
        while (budget > 0) begin
            if ($urandom_range(0, 9) < 7) begin
                run_move(budget);
            end else begin
                send_item($urandom_range(0, 1), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
                budget--;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: ticks with no target, extreme targets and poses, headings at
        // zero, half and full turn, a pose on the target, and clearing the target.
        send_item(0, 0, 0, 0);
        send_item(0, 32767, -32768, 16'hFFFF);
        send_item(1, 32767, 32767, 0);
        send_item(0, -32768, -32768, 16'h8000);
        send_item(0, -32768, -32768, 16'h2000);
        send_item(0, -32768, -32768, 16'h2000);
        send_item(0, 32767, 32767, 0);
        send_item(1, -32768, -32768, 0);
        send_item(0, 32767, 32767, 16'hFFFF);
        send_item(0, 32767, 32767, 16'hA000);
        send_item(0, -32768, -32768, 16'h7FFF);
        send_item(1, 0, 0, 0);
        send_item(0, 0, 0, 16'h8000);
        send_item(1, 100, 0, 0);
        send_item(0, 0, 0, 0);
        send_item(0, 0, 0, 0);
        send_item(0, 0, 0, 0);
        send_item(0, 95, 0, 0);
        send_item(0, 99, 0, 0);
        send_item(0, 100, 0, 0);
        send_item(0, 0, 0, 0);
        drain();

        random_phase(N_RANDOM / 4);
        drain();
        write_settings(255, 255, 255, 255, 16384, 65535, 65535);
        random_phase(N_RANDOM / 4);
        drain();
        write_settings(0, 0, 0, 0, 0, 0, 0);
        random_phase(N_RANDOM / 8);
        drain();
        write_settings($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 16384), $urandom_range(0, 400),
                       $urandom_range(0, 40));
        random_phase(N_RANDOM / 8);
        drain();
        write_settings(120, 80, 150, 50, 1043, 50, 10);
        random_phase(N_RANDOM / 4);
        drain();

        $display("Run covered %0d items and %0d checked results over five register settings.",
                 items_sent, checked);
        if (fail_count == 0)
            $display("go_to_point_rotate_then_drive_test: clean");
        else
            $display("go_to_point_rotate_then_drive_test: errors");
        $finish;
    end
endmodule

>>> files.f
rtl/gtp_pkg.sv
rtl/gtp_cordic.sv
rtl/gtp_div.sv
rtl/go_to_point_rotate_then_drive.sv
tb/sv/go_to_point_rotate_then_drive_check.sv
tb/sv/go_to_point_rotate_then_drive_test.sv
